// ===== rtl/core/amou_pkg.sv =====
// Shared types and constants of the atomic memory operation unit.
package amou_pkg;

    localparam int CMD_W  = 3;
    localparam int ADDR_W = 8;
    localparam int DATA_W = 32;

    // Command codes carried by each input beat
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD  = 3'd0,
        CMD_SUB  = 3'd1,
        CMD_AND  = 3'd2,
        CMD_OR   = 3'd3,
        CMD_XCHG = 3'd4,
        CMD_CMPX = 3'd5,
        CMD_TAS  = 3'd6,
        CMD_CLR  = 3'd7
    } t_cmd;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // latch the input beat and read the addressed word
        logic write_back;  // write the new word and load the result register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;    // result register empty or being taken this cycle
    } t_dp_status;

endpackage

// ===== rtl/core/atomic_memory_op_unit.sv =====
// Top level of the atomic memory operation unit: controller plus datapath.
//
//   beat       handshake           payload
//   input      i_valid / o_ready   i_command, i_address, i_operand, i_expected_value
//   result     o_valid / i_ready   o_old_value, o_success
//
// Each command is handled in a capture step, which latches the beat and reads the word from the
// single-port store, and an update step, which writes the new word back and loads the result register.
// Reset clears the store at once through per-word written flags; no clearing pass.
// A stalled result register holds the update stage; one result can wait while the
// next beat is accepted and read.
module atomic_memory_op_unit #(
    parameter int WORD_COUNT = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [amou_pkg::CMD_W-1:0]     i_command,
    input  logic [amou_pkg::ADDR_W-1:0]    i_address,
    input  logic [amou_pkg::DATA_W-1:0]    i_operand,
    input  logic [amou_pkg::DATA_W-1:0]    i_expected_value,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [amou_pkg::DATA_W-1:0]    o_old_value,
    output logic                           o_success
);

    amou_pkg::t_dp_cmd    dp_cmd;
    amou_pkg::t_dp_status dp_status;

    amou_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .o_dp_cmd    (dp_cmd),
        .i_dp_status (dp_status)
    );

    amou_dpath #(
        .WORD_COUNT (WORD_COUNT)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_dp_cmd         (dp_cmd),
        .o_dp_status      (dp_status),
        .i_command        (i_command),
        .i_address        (i_address),
        .i_operand        (i_operand),
        .i_expected_value (i_expected_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_old_value      (o_old_value),
        .o_success        (o_success)
    );

endmodule

// ===== rtl/core/amou_ctrl.sv =====
// Controller state machine of the atomic memory operation unit.
module amou_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    output amou_pkg::t_dp_cmd     o_dp_cmd,
    input  amou_pkg::t_dp_status  i_dp_status
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state r_state;
    logic   r_ready;

    // Hold state; ready is a registered output, high only while idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_ready <= 1'b1;
                    if (i_valid && r_ready) begin
                        r_state <= ST_EXEC;
                        r_ready <= 1'b0;
                    end
                end
                ST_EXEC: begin
                    if (i_dp_status.out_free) begin
                        r_state <= ST_IDLE;
                        r_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    assign o_ready = r_ready;

    // Drive datapath commands from state
    always_comb begin
        o_dp_cmd.capture    = (r_state == ST_IDLE) && i_valid && r_ready;
        o_dp_cmd.write_back = (r_state == ST_EXEC) && i_dp_status.out_free;
    end

    // An accepted beat always moves the controller into execution
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ST_EXEC))
        else $error("accepted beat did not start execution");

    // Ready is never offered while a beat is executing
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> !o_ready)
        else $error("ready raised during execution");

endmodule

// ===== rtl/core/amou_dpath.sv =====
// Datapath of the atomic memory operation unit: word store, update logic, result register.
module amou_dpath #(
    parameter int WORD_COUNT = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  amou_pkg::t_dp_cmd              i_dp_cmd,
    output amou_pkg::t_dp_status           o_dp_status,
    input  logic [amou_pkg::CMD_W-1:0]     i_command,
    input  logic [amou_pkg::ADDR_W-1:0]    i_address,
    input  logic [amou_pkg::DATA_W-1:0]    i_operand,
    input  logic [amou_pkg::DATA_W-1:0]    i_expected_value,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [amou_pkg::DATA_W-1:0]    o_old_value,
    output logic                           o_success
);

    // Only the words that an 8-bit address can reach are stored
    localparam int ADDR_SPAN = 1 << amou_pkg::ADDR_W;
    localparam int DEPTH     = (WORD_COUNT < ADDR_SPAN) ? WORD_COUNT : ADDR_SPAN;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [amou_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]            r_written;

    amou_pkg::t_cmd              r_cmd;
    logic [AW-1:0]               r_idx;
    logic                        r_in_range;
    logic [amou_pkg::DATA_W-1:0] r_operand;
    logic [amou_pkg::DATA_W-1:0] r_expected;
    logic [amou_pkg::DATA_W-1:0] r_rd_data;
    logic                        r_rd_written;

    logic                        r_out_valid;
    logic [amou_pkg::DATA_W-1:0] r_old_value;
    logic                        r_success;

    logic                        n_in_range;
    logic [AW-1:0]               n_idx;
    logic [amou_pkg::DATA_W-1:0] n_old;
    logic [amou_pkg::DATA_W-1:0] n_word;
    logic                        n_success;

    assign n_in_range = {1'b0, i_address} < (amou_pkg::ADDR_W + 1)'(DEPTH);
    assign n_idx      = i_address[AW-1:0];

    // Latch the beat; read the addressed word and its written flag
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_cmd      <= amou_pkg::t_cmd'(i_command);
            r_idx      <= n_idx;
            r_in_range <= n_in_range;
            r_operand  <= i_operand;
            r_expected <= i_expected_value;
            if (n_in_range) begin
                r_rd_data    <= r_mem[n_idx];
                r_rd_written <= r_written[n_idx];
            end else begin
                r_rd_data    <= '0;
                r_rd_written <= 1'b0;
            end
        end
        if (i_dp_cmd.write_back && r_in_range) begin
            r_mem[r_idx] <= n_word;
        end
    end

    // Word not written since reset reads as zero
    assign n_old = (r_in_range && r_rd_written) ? r_rd_data : '0;

    // Compute the new word and the success flag
    always_comb begin
        n_word    = n_old;
        n_success = 1'b0;
        unique case (r_cmd)
            amou_pkg::CMD_ADD:  n_word = n_old + r_operand;
            amou_pkg::CMD_SUB:  n_word = n_old - r_operand;
            amou_pkg::CMD_AND:  n_word = n_old & r_operand;
            amou_pkg::CMD_OR:   n_word = n_old | r_operand;
            amou_pkg::CMD_XCHG: n_word = r_operand;
            amou_pkg::CMD_CMPX: begin
                if (n_old == r_expected) begin
                    n_word    = r_operand;
                    n_success = 1'b1;
                end
            end
            amou_pkg::CMD_TAS: begin
                n_word    = amou_pkg::DATA_W'(1);
                n_success = (n_old != '0);
            end
            amou_pkg::CMD_CLR:  n_word = '0;
        endcase
    end

    // Track written words and the result register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_dp_cmd.write_back && r_in_range) begin
                r_written[r_idx] <= 1'b1;
            end
            if (i_dp_cmd.write_back) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.write_back) begin
            r_old_value <= n_old;
            r_success   <= r_in_range && n_success;
        end
    end

    assign o_dp_status.out_free = !r_out_valid || i_ready;
    assign o_valid              = r_out_valid;
    assign o_old_value          = r_old_value;
    assign o_success            = r_success;

    // Never overwrite a result that has not been taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.write_back |-> (!r_out_valid || i_ready))
        else $error("result register overwritten");

    // Capture and write-back never fall in the same cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_dp_cmd.capture && i_dp_cmd.write_back))
        else $error("capture and write-back overlap");

    // Success only for compare-exchange and test-and-set
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dp_cmd.write_back && !(r_cmd == amou_pkg::CMD_CMPX || r_cmd == amou_pkg::CMD_TAS))
        |=> !o_success)
        else $error("success raised for a plain command");

    // An out-of-range address returns zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dp_cmd.write_back && !r_in_range) |=> (o_old_value == '0 && !o_success))
        else $error("out-of-range command returned data");

endmodule

// ===== verif/amou_checker.sv =====
// Checker for the atomic memory operation unit: mirrors the word store and scores each result.
module amou_checker #(
    parameter int WORD_COUNT = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_ready_in,
    input  logic [amou_pkg::CMD_W-1:0]  i_command,
    input  logic [amou_pkg::ADDR_W-1:0] i_address,
    input  logic [amou_pkg::DATA_W-1:0] i_operand,
    input  logic [amou_pkg::DATA_W-1:0] i_expected_value,
    input  logic                        i_result_valid,
    input  logic                        i_result_ready,
    input  logic [amou_pkg::DATA_W-1:0] i_old_value,
    input  logic                        i_success,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [amou_pkg::DATA_W-1:0] old_value;
        logic                        success;
    } t_atomic_result;

    logic [amou_pkg::DATA_W-1:0] word_mirror [WORD_COUNT];
    t_atomic_result              pending_results [$];
    t_atomic_result              oldest;
    int                          fail_count;
    int                          checked_count;

    assign o_fail_count = fail_count;
    assign o_checked    = checked_count;

    // Apply one command to the mirrored store and return what the unit should report
    function automatic t_atomic_result execute_atomic(
        input amou_pkg::t_cmd              cmd,
        input logic [amou_pkg::ADDR_W-1:0] addr,
        input logic [amou_pkg::DATA_W-1:0] opnd,
        input logic [amou_pkg::DATA_W-1:0] expv
    );
        t_atomic_result              res;
        logic [amou_pkg::DATA_W-1:0] next_word;
        res.old_value = '0;
        res.success   = 1'b0;
        if (int'(addr) < WORD_COUNT) begin
            res.old_value = word_mirror[addr];
            next_word     = res.old_value;
            case (cmd)
                amou_pkg::CMD_ADD:  next_word = res.old_value + opnd;
                amou_pkg::CMD_SUB:  next_word = res.old_value - opnd;
                amou_pkg::CMD_AND:  next_word = res.old_value & opnd;
                amou_pkg::CMD_OR:   next_word = res.old_value | opnd;
                amou_pkg::CMD_XCHG: next_word = opnd;
                amou_pkg::CMD_CMPX: begin
                    if (res.old_value == expv) begin
                        next_word   = opnd;
                        res.success = 1'b1;
                    end
                end
                amou_pkg::CMD_TAS: begin
                    next_word   = 32'd1;
                    res.success = (res.old_value != '0);
                end
                default:  next_word = '0;
            endcase
            word_mirror[addr] = next_word;
        end
        return res;
    endfunction

    // Count a failure; report only the first few in full
    task automatic log_failure(input string msg);
        if (fail_count < 10)
            $display("[%0t] checker: %s", $realtime, msg);
        fail_count++;
    endtask

    // Score the result beat first, then predict for the input beat of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (word_mirror[i])
                word_mirror[i] = '0;
            pending_results.delete();
        end else begin
            if (i_result_valid && i_result_ready) begin
                if (pending_results.size() == 0) begin
                    log_failure($sformatf("result beat with nothing due: old_value %h success %b",
                                          i_old_value, i_success));
                end else begin
                    oldest = pending_results.pop_front();
                    if (i_old_value !== oldest.old_value || i_success !== oldest.success)
                        log_failure($sformatf(
                            "result %0d: old_value exp %h got %h, success exp %b got %b",
                            checked_count, oldest.old_value, i_old_value,
                            oldest.success, i_success));
                    checked_count++;
                end
            end
            if (i_valid && i_ready_in)
                pending_results.push_back(execute_atomic(amou_pkg::t_cmd'(i_command),
                                                         i_address, i_operand,
                                                         i_expected_value));
        end
        o_pending = pending_results.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the atomic memory operation unit: clock, reset, stimulus and verdict.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_COUNT   = 256;
    localparam int RANDOM_BEATS = 1130;
    localparam int STALL_PCT    = 36;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_ready;
    logic [amou_pkg::CMD_W-1:0]  i_command;
    logic [amou_pkg::ADDR_W-1:0] i_address;
    logic [amou_pkg::DATA_W-1:0] i_operand;
    logic [amou_pkg::DATA_W-1:0] i_expected_value;
    logic                        o_valid;
    logic                        i_ready;
    logic [amou_pkg::DATA_W-1:0] o_old_value;
    logic                        o_success;

    int   fail_count;
    int   pending_count;
    int   checked_count;
    int   beats_sent;
    int   drain_cycles;
    logic stall_en;

    atomic_memory_op_unit #(
        .WORD_COUNT(WORD_COUNT)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_address       (i_address),
        .i_operand       (i_operand),
        .i_expected_value(i_expected_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_old_value     (o_old_value),
        .o_success       (o_success)
    );

    amou_checker #(
        .WORD_COUNT(WORD_COUNT)
    ) i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_ready_in      (o_ready),
        .i_command       (i_command),
        .i_address       (i_address),
        .i_operand       (i_operand),
        .i_expected_value(i_expected_value),
        .i_result_valid  (o_valid),
        .i_result_ready  (i_ready),
        .i_old_value     (o_old_value),
        .i_success       (o_success),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count),
        .o_checked       (checked_count)
    );

    // Free-running clock, 10 ns period
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Hard stop should the unit hang
    initial begin
        #2_000_000;
        $display("** atomic_memory_op_unit: FAILED **");
        $display("timeout with %0d results still due", pending_count);
        $finish;
    end

    // Result side: take every beat, or stall at random while stalling is enabled
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_ready <= 1'b0;
        else if (stall_en)
            i_ready <= ($urandom_range(0, 99) >= STALL_PCT);
        else
            i_ready <= 1'b1;
    end

    // Present one command beat and hold it until the unit takes it
    task automatic send_command(
        input amou_pkg::t_cmd              cmd,
        input logic [amou_pkg::ADDR_W-1:0] addr,
        input logic [amou_pkg::DATA_W-1:0] opnd,
        input logic [amou_pkg::DATA_W-1:0] expv
    );
        while (stall_en && $urandom_range(0, 99) < STALL_PCT) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid          <= 1'b1;
        i_command        <= cmd;
        i_address        <= addr;
        i_operand        <= opnd;
        i_expected_value <= expv;
        do
            @(posedge i_clk);
        while (!o_ready);
        beats_sent++;
    endtask

    // Pick an operand from a mix of wide random, tiny and boundary values
    function automatic logic [amou_pkg::DATA_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return $urandom;
        else if (sel < 70)
            return amou_pkg::DATA_W'($urandom_range(0, 3));
        else if (sel < 85)
            return '1;
        else
            return amou_pkg::DATA_W'(1) << $urandom_range(0, amou_pkg::DATA_W - 1);
    endfunction

    // Favour a handful of hot words so that commands collide back to back
    function automatic logic [amou_pkg::ADDR_W-1:0] pick_address();
        if ($urandom_range(0, 99) < 55)
            return amou_pkg::ADDR_W'($urandom_range(0, 3));
        return amou_pkg::ADDR_W'($urandom_range(0, WORD_COUNT - 1));
    endfunction

    initial begin
        amou_pkg::t_cmd cmd;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_command        = '0;
        i_address        = '0;
        i_operand        = '0;
        i_expected_value = '0;
        stall_en         = 1'b0;
        beats_sent       = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: wrap-around, every command, both compare-exchange outcomes,
        // test-and-set on zero and nonzero words, end addresses, same-address chains
        send_command(amou_pkg::CMD_ADD,  8'd0,   32'hFFFF_FFFF, 32'h0);
        send_command(amou_pkg::CMD_ADD,  8'd0,   32'h0000_0001, 32'h0);
        send_command(amou_pkg::CMD_SUB,  8'd0,   32'h0000_0001, 32'h0);
        send_command(amou_pkg::CMD_AND,  8'd0,   32'h0F0F_0F0F, 32'h0);
        send_command(amou_pkg::CMD_OR,   8'd255, 32'h8000_0000, 32'h0);
        send_command(amou_pkg::CMD_XCHG, 8'd255, 32'hFFFF_FFFF, 32'h0);
        send_command(amou_pkg::CMD_CMPX, 8'd255, 32'h1234_5678, 32'hFFFF_FFFF);
        send_command(amou_pkg::CMD_CMPX, 8'd255, 32'hDEAD_BEEF, 32'h0);
        send_command(amou_pkg::CMD_TAS,  8'd1,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(amou_pkg::CMD_TAS,  8'd1,   32'h0,         32'h0);
        send_command(amou_pkg::CMD_CLR,  8'd1,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(amou_pkg::CMD_TAS,  8'd1,   32'h0,         32'h0);
        send_command(amou_pkg::CMD_CMPX, 8'd2,   32'h0,         32'h0);
        send_command(amou_pkg::CMD_SUB,  8'd2,   32'hFFFF_FFFF, 32'h0);
        send_command(amou_pkg::CMD_XCHG, 8'h55,  32'hAAAA_AAAA, 32'h5555_5555);
        send_command(amou_pkg::CMD_XCHG, 8'hAA,  32'h5555_5555, 32'hAAAA_AAAA);
        send_command(amou_pkg::CMD_OR,   8'h55,  32'h5555_5555, 32'h0);
        send_command(amou_pkg::CMD_AND,  8'h55,  32'h0,         32'h0);
        send_command(amou_pkg::CMD_CLR,  8'd255, 32'h0,         32'h0);
        send_command(amou_pkg::CMD_ADD,  8'h80,  32'h8000_0000, 32'h0);
        send_command(amou_pkg::CMD_ADD,  8'h80,  32'h8000_0000, 32'h0);

        // Random: stalls on both sides, with a quiet stretch in the middle
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            stall_en = !(n >= 400 && n < 700);
            cmd      = amou_pkg::t_cmd'($urandom_range(0, 7));
            send_command(cmd, pick_address(), pick_word(), pick_word());
        end
        @(negedge i_clk);
        i_valid  <= 1'b0;
        stall_en = 1'b0;

        // Drain outstanding results, then wait on for any stray beats
        drain_cycles = 0;
        while (pending_count != 0 && drain_cycles < 5000) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        repeat (8) @(negedge i_clk);

        $display("covered %0d command beats over all eight commands, hot-word collisions",
                 beats_sent);
        $display("and random stalls on both sides; %0d results compared, %0d still due",
                 checked_count, pending_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("** atomic_memory_op_unit: PASSED **");
        end else begin
            $display("** atomic_memory_op_unit: FAILED **");
        end
        $finish;
    end

endmodule
